>>> rtl/smf_pkg.sv
// smf_pkg: shared constants and types of the sliding median filter
// depends on nothing; imported by all modules but smf_queue
package smf_pkg;

  // width and reset value of the window length register
  localparam int unsigned WLEN_W = 4;
  localparam logic [WLEN_W-1:0] WLEN_RESET = 4'd5;

  // lengths below this value pass samples straight through
  localparam logic [WLEN_W-1:0] WLEN_MEDIAN_MIN = 4'd2;

  // back end sequencer states, one-hot
  typedef enum logic [1:0] {
    BK_IDLE = 2'b01,
    BK_SCAN = 2'b10
  } back_state_t;

endpackage

>>> rtl/smf_queue.sv
// smf_queue: small register fifo carrying median jobs from front to back
// depends on nothing outside this file
module smf_queue #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             push_fire, pop_fire;

  assign push_ready = (fill_r != CNT_W'(DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push_fire) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_fire) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_fire && !pop_fire) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop_fire && !push_fire) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/smf_front.sv
// smf_front: takes samples, keeps the history and count, issues median jobs
// depends on smf_pkg
module smf_front #(
  parameter int MAX_WINDOW   = 15,
  parameter int SAMPLE_WIDTH = 32,
  parameter int IDX_W        = 4
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  // configuration write
  input  logic                                       cfg_valid,
  input  logic [smf_pkg::WLEN_W-1:0]                 cfg_data,
  // sample request
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  logic [SAMPLE_WIDTH-1:0]                    in_sample,
  input  logic                                       in_last,
  // downstream is drained
  input  logic                                       drain_idle,
  // history seen by the back end
  output logic [MAX_WINDOW-1:0][SAMPLE_WIDTH-1:0]    hist,
  // job request
  output logic                                       job_valid,
  input  logic                                       job_ready,
  output logic [IDX_W-1:0]                           job_hi,
  output logic                                       job_last
);
  import smf_pkg::*;

  localparam int CNT_W    = $clog2(MAX_WINDOW + 1);
  localparam int HALF_MAX = (MAX_WINDOW - 1) / 2;

  logic [WLEN_W-1:0]                     wlen_r;
  logic [MAX_WINDOW-1:0][SAMPLE_WIDTH-1:0] hist_r, hist_nxt;
  logic [CNT_W-1:0]                      cnt_r, cnt_nxt;
  logic                                  gen_r, gen_nxt;
  logic                                  final_r, final_nxt;
  logic [IDX_W-1:0]                      pos_r, pos_nxt;
  logic [IDX_W-1:0]                      half_r, half_nxt;
  logic [IDX_W-1:0]                      cntm1_r, cntm1_nxt;

  logic                                  in_fire, job_fire, pass;
  logic [WLEN_W-2:0]                     wlen_half;
  logic [IDX_W-1:0]                      half_c, cntm1_c;
  logic [CNT_W-1:0]                      cnt_inc;
  logic [IDX_W:0]                        reach;

  assign in_ready = !gen_r && drain_idle;
  assign in_fire  = in_valid && in_ready;
  assign job_fire = job_valid && job_ready;
  assign hist     = hist_r;

  // window length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r <= WLEN_RESET;
    end else if (cfg_valid) begin
      wlen_r <= cfg_data;
    end
  end

  // classify the incoming sample
  always_comb begin
    pass      = (wlen_r < WLEN_MEDIAN_MIN);
    wlen_half = wlen_r[WLEN_W-1:1];
    if (pass) begin
      half_c = '0;
    end else if (int'(wlen_half) > HALF_MAX) begin
      half_c = IDX_W'(HALF_MAX);
    end else begin
      half_c = IDX_W'(wlen_half);
    end
    cnt_inc = (cnt_r < CNT_W'(MAX_WINDOW)) ? cnt_r + 1'b1 : cnt_r;
    cntm1_c = IDX_W'(cnt_inc - 1'b1);
  end

  // history shift, count and job generator
  always_comb begin
    hist_nxt  = hist_r;
    cnt_nxt   = cnt_r;
    gen_nxt   = gen_r;
    final_nxt = final_r;
    pos_nxt   = pos_r;
    half_nxt  = half_r;
    cntm1_nxt = cntm1_r;
    if (in_fire) begin
      hist_nxt[0] = in_sample;
      for (int i = 1; i < MAX_WINDOW; i++) begin
        hist_nxt[i] = hist_r[i-1];
      end
      cnt_nxt   = in_last ? '0 : cnt_inc;
      final_nxt = in_last;
      half_nxt  = half_c;
      cntm1_nxt = cntm1_c;
      gen_nxt   = pass || in_last || (cnt_inc > CNT_W'(half_c));
      if (in_last && (cntm1_c < half_c)) begin
        pos_nxt = cntm1_c;
      end else begin
        pos_nxt = half_c;
      end
    end else if (job_fire) begin
      if (final_r && (pos_r != '0)) begin
        pos_nxt = pos_r - 1'b1;
      end else begin
        gen_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      gen_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      gen_r <= gen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hist_r  <= hist_nxt;
    final_r <= final_nxt;
    pos_r   <= pos_nxt;
    half_r  <= half_nxt;
    cntm1_r <= cntm1_nxt;
  end

  // top of the truncated window for the current job
  assign reach     = {1'b0, pos_r} + {1'b0, half_r};
  assign job_valid = gen_r;
  assign job_hi    = (reach > {1'b0, cntm1_r}) ? cntm1_r : reach[IDX_W-1:0];
  assign job_last  = final_r && (pos_r == '0);

endmodule

>>> rtl/smf_back.sv
// smf_back: rank selection over the window, one candidate per cycle while
// scanning and not held by a full output; depends on smf_pkg; drives the output register
module smf_back #(
  parameter int MAX_WINDOW   = 15,
  parameter int SAMPLE_WIDTH = 32,
  parameter int IDX_W        = 4
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic [MAX_WINDOW-1:0][SAMPLE_WIDTH-1:0] hist,
  // job request
  input  logic                                    job_valid,
  output logic                                    job_ready,
  input  logic [IDX_W-1:0]                        job_hi,
  input  logic                                    job_last,
  // result request
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [SAMPLE_WIDTH-1:0]                 out_median,
  output logic                                    out_last,
  output logic                                    busy
);
  import smf_pkg::*;

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);

  back_state_t               state_r, state_nxt;
  logic [IDX_W-1:0]          hi_r, hi_nxt;
  logic [IDX_W-1:0]          cand_r, cand_nxt;
  logic                      last_r, last_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [SAMPLE_WIDTH-1:0]   out_median_r, out_median_nxt;
  logic                      out_last_r, out_last_nxt;

  logic [SAMPLE_WIDTH-1:0]   cand_val;
  logic [MAX_WINDOW-1:0]     lt_vec, eq_vec;
  logic [CNT_W:0]            less_cnt, upto_cnt, rank;
  logic                      match, hit, out_free;

  assign job_ready  = (state_r == BK_IDLE);
  assign busy       = (state_r == BK_SCAN);
  assign out_free   = !out_valid_r || out_ready;
  assign out_valid  = out_valid_r;
  assign out_median = out_median_r;
  assign out_last   = out_last_r;

  // compare the candidate against every entry of the window
  always_comb begin
    cand_val = hist[cand_r];
    for (int b = 0; b < MAX_WINDOW; b++) begin
      lt_vec[b] = (IDX_W'(b) <= hi_r) && ($signed(hist[b]) < $signed(cand_val));
      eq_vec[b] = (IDX_W'(b) <= hi_r) && (hist[b] == cand_val);
    end
    less_cnt = (CNT_W + 1)'($countones(lt_vec));
    upto_cnt = less_cnt + (CNT_W + 1)'($countones(eq_vec));
    rank     = ((CNT_W + 1)'(hi_r) + 1'b1) >> 1;
    match    = (less_cnt <= rank) && (rank < upto_cnt);
    hit      = match || (cand_r == hi_r);
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    hi_nxt         = hi_r;
    cand_nxt       = cand_r;
    last_nxt       = last_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_median_nxt = out_median_r;
    out_last_nxt   = out_last_r;
    unique case (state_r)
      BK_IDLE: begin
        if (job_valid) begin
          hi_nxt    = job_hi;
          last_nxt  = job_last;
          cand_nxt  = '0;
          state_nxt = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (hit) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_median_nxt = cand_val;
            out_last_nxt   = last_r;
            state_nxt      = BK_IDLE;
          end
        end else begin
          cand_nxt = cand_r + 1'b1;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r         <= hi_nxt;
    cand_r       <= cand_nxt;
    last_r       <= last_nxt;
    out_median_r <= out_median_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule

>>> rtl/sliding_median_filter.sv
// sliding_median_filter: top level of the centered sliding-window median
// depends on smf_pkg, smf_front, smf_queue and smf_back
//
// Usage: one sample per in_ request (tdata = sample, tlast = final sample
// of a curve); medians leave on out_ with tlast on the curve's final result.
// cfg_data sets the window length (reset 5, even raised by one, 0 or 1 passes
// through); write it only while the filter is idle. cfg_ready is always high.
// The front end shifts the sample into the history and issues one job per
// result into a two-entry queue; the back end ranks one candidate per cycle
// against the whole window while scanning, holding on the chosen candidate
// while the output register is full; each result first loads its job and
// then scans the window entries (up to MAX_WINDOW). A new sample is taken
// once all jobs of the previous one have been ranked; a final sample emits
// up to (MAX_WINDOW-1)/2 + 1 results, each needing its own load and scan.
// Reset empties the history count, the queue and the output register. A
// stalled receiver holds the output register, which stops the back end,
// then the queue, then the sample input.
module sliding_median_filter #(
  parameter int MAX_WINDOW   = 15,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [smf_pkg::WLEN_W-1:0]    cfg_data,   // window_len
  // samples in
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] in_tdata,   // sample_in
  input  logic                          in_tlast,
  // medians out
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0] out_tdata,  // median_out
  output logic                          out_tlast
);
  import smf_pkg::*;

  localparam int DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int JOB_W  = IDX_W + 1;

  logic [MAX_WINDOW-1:0][SAMPLE_WIDTH-1:0] hist;
  logic                    job_valid, job_ready, job_last;
  logic [IDX_W-1:0]        job_hi;
  logic                    q_valid, q_ready;
  logic [JOB_W-1:0]        q_data;
  logic                    back_busy, drain_idle;
  logic [SAMPLE_WIDTH-1:0] median;

  assign cfg_ready  = 1'b1;
  assign drain_idle = !q_valid && !back_busy;
  assign out_tdata  = DATA_W'(median);

  // front end: history, count and job issue
  smf_front #(
    .MAX_WINDOW   (MAX_WINDOW),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .IDX_W        (IDX_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_sample  (in_tdata[SAMPLE_WIDTH-1:0]),
    .in_last    (in_tlast),
    .drain_idle (drain_idle),
    .hist       (hist),
    .job_valid  (job_valid),
    .job_ready  (job_ready),
    .job_hi     (job_hi),
    .job_last   (job_last)
  );

  // job queue between the two ends
  smf_queue #(
    .WIDTH (JOB_W),
    .DEPTH (2)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (job_valid),
    .push_ready (job_ready),
    .push_data  ({job_hi, job_last}),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  // back end: rank selection and output register
  smf_back #(
    .MAX_WINDOW   (MAX_WINDOW),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .IDX_W        (IDX_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .hist       (hist),
    .job_valid  (q_valid),
    .job_ready  (q_ready),
    .job_hi     (q_data[JOB_W-1:1]),
    .job_last   (q_data[0]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_median (median),
    .out_last   (out_tlast),
    .busy       (back_busy)
  );

`ifndef SYNTHESIS
  // history may only move when no job is pending or being ranked
  a_accept_drained: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!q_valid && !back_busy))
    else $error("sample request taken while jobs are pending");

  // the front end never takes a sample while it still issues jobs
  a_no_accept_issuing: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid |-> !in_tready)
    else $error("sample request taken while issuing jobs");

  // a job stalled by a full queue holds its contents
  a_job_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (job_valid && !job_ready) |=> (job_valid && $stable(job_hi) && $stable(job_last)))
    else $error("stalled job changed");
`endif

endmodule
